>>> rtl/kee_pkg.sv
// ----------------------------------------------------------------------------
// kee_pkg
// Shared types and constants of the kinetic energy expectation unit.
// ----------------------------------------------------------------------------
`default_nettype none

package kee_pkg;

   localparam int COMP_W  = 24;           // G and psi components
   localparam int NCOMP   = 5;            // gx, gy, gz, psi_re, psi_im
   localparam int WGT_W   = 16;
   localparam int SQ_W    = 47;           // square of a 24-bit signed value
   localparam int GG_W    = 48;           // |G|^2, 30 fractional bits
   localparam int PP_W    = 48;           // |psi|^2, 44 fractional bits
   localparam int PW_W    = 64;           // |psi|^2 * weight
   localparam int HALF_GG = 24;
   localparam int HALF_PW = 32;
   localparam int PART_W  = HALF_GG + HALF_PW;
   localparam int PAIR_W  = PART_W + HALF_PW;
   localparam int PROD_W  = 113;          // full product plus one guard bit
   localparam int MAG_W   = 56;
   localparam int ACC_W   = 64;
   localparam int SHIFT_PACKED = 56;
   localparam int SHIFT_PLAIN  = 57;

   localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
   localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};

   typedef struct packed {
      logic load;
      logic sq;
      logic sum;
      logic pw;
      logic part;
      logic add1;
      logic add2;
      logic acc;
      logic fin;
   } kee_cmd_type;

   typedef struct packed {
      logic last_item;
      logic out_free;
   } kee_status_type;

   function automatic logic [SQ_W-1:0] square_comp(input logic signed [COMP_W-1:0] v);
      logic signed [2*COMP_W-1:0] p;
      p = v * v;
      return p[SQ_W-1:0];
   endfunction

endpackage

`default_nettype wire

>>> rtl/kee_ctrl.sv
// ----------------------------------------------------------------------------
// kee_ctrl
// Sequencer that steps one coefficient beat through the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module kee_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   input  wire kee_pkg::kee_status_type status,
   output kee_pkg::kee_cmd_type         cmd
);
   import kee_pkg::*;

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_SQ   = 4'd1;
   localparam logic [3:0] ST_SUM  = 4'd2;
   localparam logic [3:0] ST_PW   = 4'd3;
   localparam logic [3:0] ST_PART = 4'd4;
   localparam logic [3:0] ST_ADD1 = 4'd5;
   localparam logic [3:0] ST_ADD2 = 4'd6;
   localparam logic [3:0] ST_ACC  = 4'd7;
   localparam logic [3:0] ST_FIN  = 4'd8;

   logic [3:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_SQ;
            end
         end
         ST_SQ: begin
            cmd.sq   = 1'b1;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            cmd.sum  = 1'b1;
            state_in = ST_PW;
         end
         ST_PW: begin
            cmd.pw   = 1'b1;
            state_in = ST_PART;
         end
         ST_PART: begin
            cmd.part = 1'b1;
            state_in = ST_ADD1;
         end
         ST_ADD1: begin
            cmd.add1 = 1'b1;
            state_in = ST_ADD2;
         end
         ST_ADD2: begin
            cmd.add2 = 1'b1;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            cmd.acc  = 1'b1;
            state_in = status.last_item ? ST_FIN : ST_IDLE;
         end
         ST_FIN: begin
            // Wait here until the result register can take the energy.
            if (status.out_free) begin
               cmd.fin  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_tready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTHESIS
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ST_SQ))
      else $error("accepted beat did not start the sequence");

   a_fin_only_after_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ACC && !status.last_item) |=> (state_ff == ST_IDLE))
      else $error("non-last beat did not return to idle");

   a_state_legal: assert property (@(posedge clock) disable iff (reset)
      state_ff <= ST_FIN)
      else $error("sequencer state out of range");
`endif

endmodule

`default_nettype wire

>>> rtl/kee_datapath.sv
// ----------------------------------------------------------------------------
// kee_datapath
// Squares, products, rounding, saturating accumulator and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module kee_datapath (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire kee_pkg::kee_cmd_type           cmd,
   output kee_pkg::kee_status_type             status,
   input  wire logic [kee_pkg::COMP_W-1:0]     in_gx,
   input  wire logic [kee_pkg::COMP_W-1:0]     in_gy,
   input  wire logic [kee_pkg::COMP_W-1:0]     in_gz,
   input  wire logic [kee_pkg::COMP_W-1:0]     in_psi_re,
   input  wire logic [kee_pkg::COMP_W-1:0]     in_psi_im,
   input  wire logic [kee_pkg::WGT_W-1:0]      in_weight,
   input  wire logic                           in_packed_region,
   input  wire logic                           in_last,
   input  wire logic                           csr_we,
   input  wire logic                           csr_wdata,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic [kee_pkg::ACC_W-1:0]           rsp_energy,
   output logic                                rsp_saturated
);
   import kee_pkg::*;

   logic signed [COMP_W-1:0] comp_ff [NCOMP];
   logic [WGT_W-1:0]         weight_ff;
   logic                     packed_ff;
   logic                     last_ff;
   logic [SQ_W-1:0]          sq_ff [NCOMP];
   logic [GG_W-1:0]          gg_ff;
   logic [PP_W-1:0]          pp_ff;
   logic [PW_W-1:0]          pw_ff;
   logic [PART_W-1:0]        p_ll_ff, p_lh_ff, p_hl_ff, p_hh_ff;
   logic [PAIR_W-1:0]        pair_a_ff, pair_b_ff;
   logic [MAG_W-1:0]         mag_ff, mag_in;
   logic [PROD_W-1:0]        prod_rnd;
   logic [ACC_W-1:0]         sum_ff, sum_in;
   logic                     ov_ff, ov_in;
   logic                     spin_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [ACC_W-1:0]         rsp_energy_ff;
   logic                     rsp_sat_ff;
   logic [ACC_W:0]           diff;
   logic [ACC_W-1:0]         dbl, neg;
   logic                     dbl_sat, neg_sat;

   assign status.last_item = last_ff;
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

   // Operand capture and arithmetic steps; no reset on payload.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         comp_ff[0] <= in_gx;
         comp_ff[1] <= in_gy;
         comp_ff[2] <= in_gz;
         comp_ff[3] <= in_psi_re;
         comp_ff[4] <= in_psi_im;
         weight_ff  <= in_weight;
         packed_ff  <= in_packed_region;
         last_ff    <= in_last;
      end
      if (cmd.sq) begin
         for (int i = 0; i < NCOMP; i++) begin
            sq_ff[i] <= square_comp(comp_ff[i]);
         end
      end
      if (cmd.sum) begin
         gg_ff <= GG_W'(sq_ff[0]) + GG_W'(sq_ff[1]) + GG_W'(sq_ff[2]);
         pp_ff <= PP_W'(sq_ff[3]) + PP_W'(sq_ff[4]);
      end
      if (cmd.pw) begin
         pw_ff <= pp_ff * weight_ff;
      end
      if (cmd.part) begin
         p_ll_ff <= gg_ff[HALF_GG-1:0]      * pw_ff[HALF_PW-1:0];
         p_lh_ff <= gg_ff[HALF_GG-1:0]      * pw_ff[PW_W-1:HALF_PW];
         p_hl_ff <= gg_ff[GG_W-1:HALF_GG]   * pw_ff[HALF_PW-1:0];
         p_hh_ff <= gg_ff[GG_W-1:HALF_GG]   * pw_ff[PW_W-1:HALF_PW];
      end
      if (cmd.add1) begin
         pair_a_ff <= PAIR_W'(p_ll_ff) + {p_lh_ff, {HALF_PW{1'b0}}};
         pair_b_ff <= PAIR_W'(p_hl_ff) + {p_hh_ff, {HALF_PW{1'b0}}};
      end
      if (cmd.add2) begin
         mag_ff <= mag_in;
      end
   end

   // Round half up at the chosen shift; the packed region shifts one less.
   always_comb begin
      prod_rnd = PROD_W'(pair_a_ff) + PROD_W'({pair_b_ff, {HALF_GG{1'b0}}})
               + (PROD_W'(1) << (packed_ff ? SHIFT_PACKED - 1 : SHIFT_PLAIN - 1));
      mag_in   = packed_ff ? prod_rnd[SHIFT_PACKED +: MAG_W]
                           : prod_rnd[SHIFT_PLAIN +: MAG_W];
   end

   // Accumulate the negative term; an underflow pins the sum at the minimum.
   always_comb begin
      diff   = {sum_ff[ACC_W-1], sum_ff} - (ACC_W+1)'(mag_ff);
      sum_in = sum_ff;
      ov_in  = ov_ff;
      if (cmd.fin) begin
         sum_in = '0;
         ov_in  = 1'b0;
      end else if (cmd.acc) begin
         if (diff[ACC_W] != diff[ACC_W-1]) begin
            sum_in = ACC_MIN;
            ov_in  = 1'b1;
         end else begin
            sum_in = diff[ACC_W-1:0];
         end
      end
   end

   // Closing step: optional doubling, then negation, both saturating.
   always_comb begin
      dbl     = sum_ff;
      dbl_sat = 1'b0;
      if (spin_ff) begin
         if (sum_ff[ACC_W-1] != sum_ff[ACC_W-2]) begin
            dbl     = sum_ff[ACC_W-1] ? ACC_MIN : ACC_MAX;
            dbl_sat = 1'b1;
         end else begin
            dbl = {sum_ff[ACC_W-2:0], 1'b0};
         end
      end
      if (dbl == ACC_MIN) begin
         neg     = ACC_MAX;
         neg_sat = 1'b1;
      end else begin
         neg     = -dbl;
         neg_sat = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.fin) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= '0;
         ov_ff        <= 1'b0;
         spin_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         sum_ff       <= sum_in;
         ov_ff        <= ov_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            spin_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.fin) begin
         rsp_energy_ff <= neg;
         rsp_sat_ff    <= ov_ff | dbl_sat | neg_sat;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_energy    = rsp_energy_ff;
   assign rsp_saturated = rsp_sat_ff;

`ifndef SYNTHESIS
   a_sum_never_positive: assert property (@(posedge clock) disable iff (reset)
      !(sum_ff[ACC_W-1] == 1'b0 && sum_ff != '0))
      else $error("accumulator went positive");

   a_fin_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.fin |=> (sum_ff == '0 && !ov_ff && rsp_valid_ff))
      else $error("closing step did not clear the sum or raise the result");

   a_fin_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.fin |-> status.out_free)
      else $error("result register overwritten while still held");

   a_mag_bounded: assert property (@(posedge clock) disable iff (reset)
      cmd.acc |-> (mag_ff[MAG_W-1] == 1'b0))
      else $error("term magnitude beyond its range");
`endif

endmodule

`default_nettype wire

>>> rtl/kinetic_energy_expectation_unit.sv
// Result: the energy appears on rsp once the beat marked last has passed the closing step,
// later if the result register is still held by the previous energy.
// Flow: a new coefficient beat is taken only in the idle state, once the sequencer has stepped
// the previous beat through squares, sums, the weight product, four partial products, two adds
// and the accumulator, plus the closing step after the last beat, which waits on rsp.
// Reset: synchronous, active high; clears sequencer, sum, flag and rsp_tvalid, sets spin_paired.
// ----------------------------------------------------------------------------
// kinetic_energy_expectation_unit
// Plane-wave kinetic energy expectation over a stream of coefficients.
// ----------------------------------------------------------------------------
`default_nettype none

module kinetic_energy_expectation_unit (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // gx[23:0], gy[47:24], gz[71:48], psi_re[95:72], psi_im[119:96], weight[135:120]
   input  wire logic [135:0] req_tdata,
   // packed_region
   input  wire logic         req_tuser,
   input  wire logic         req_tlast,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // energy[63:0]
   output logic [63:0]       rsp_tdata,
   // saturated
   output logic              rsp_tuser,
   input  wire logic         csr_we,
   input  wire logic         csr_wdata
);
   import kee_pkg::*;

   kee_cmd_type    cmd;
   kee_status_type status;

   kee_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   kee_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .in_gx            (req_tdata[23:0]),
      .in_gy            (req_tdata[47:24]),
      .in_gz            (req_tdata[71:48]),
      .in_psi_re        (req_tdata[95:72]),
      .in_psi_im        (req_tdata[119:96]),
      .in_weight        (req_tdata[135:120]),
      .in_packed_region (req_tuser),
      .in_last          (req_tlast),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata),
      .rsp_valid        (rsp_tvalid),
      .rsp_ready        (rsp_tready),
      .rsp_energy       (rsp_tdata),
      .rsp_saturated    (rsp_tuser)
   );

endmodule

`default_nettype wire
